FILE: src/rde_pkg.sv
// Shared types and constants for the radix digit emitter.
// Used by rde_ctrl, rde_dp and radix_digit_emitter_top; depends on nothing.
package rde_pkg;

  localparam int RADIX_W = 6;
  localparam int LIMIT_W = 5;
  localparam int CFG_W = 6;
  localparam int CHAR_W = 7;

  localparam logic CFG_RADIX = 1'b0;
  localparam logic CFG_FRAC_LIMIT = 1'b1;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A = 7'h41;
  localparam logic [CHAR_W-1:0] ASCII_Z = 7'h5A;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 7'h39;
  localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_DIV     = 6'b000010,
    ST_EMIT_RD = 6'b000100,
    ST_EMIT_WR = 6'b001000,
    ST_POINT   = 6'b010000,
    ST_FRAC    = 6'b100000
  } state_t;

  typedef struct packed {
    logic load;        // take a new input transaction
    logic div_step;    // one bit of the serial division
    logic rd;          // read the digit store at the emit index
    logic emit_digit;  // send an integer digit and step the emit index
    logic emit_point;  // send the point
    logic frac_step;   // multiply the fraction by the base and send its digit
  } cmd_t;

  typedef struct packed {
    logic div_last;    // this division step finishes a digit
    logic div_done;    // the finished digit was the last integer digit
    logic idx_zero;    // the emit index is at the least significant digit
    logic with_frac;   // a point and fraction digits follow
    logic out_free;    // the output register can take a character
    logic frac_last;   // the current fraction digit ends the number
  } sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = CHAR_W'(d);
    if (d < RADIX_W'(10)) begin
      digit_char = ASCII_ZERO + dw;
    end else begin
      digit_char = ASCII_A + dw - CHAR_W'(10);
    end
  endfunction

endpackage

FILE: src/rde_ctrl.sv
// Controller state machine of the radix digit emitter.
// Depends on rde_pkg; drives the datapath rde_dp through cmd_t and reads sts_t.
module rde_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  rde_pkg::sts_t sts,
  output rde_pkg::cmd_t cmd
);

  rde_pkg::state_t state;
  rde_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == rde_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      rde_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = rde_pkg::ST_DIV;
        end
      end
      rde_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last && sts.div_done) begin
          state_next = rde_pkg::ST_EMIT_RD;
        end
      end
      rde_pkg::ST_EMIT_RD: begin
        cmd.rd = 1'b1;
        state_next = rde_pkg::ST_EMIT_WR;
      end
      rde_pkg::ST_EMIT_WR: begin
        if (sts.out_free) begin
          cmd.emit_digit = 1'b1;
          if (!sts.idx_zero) begin
            state_next = rde_pkg::ST_EMIT_RD;
          end else if (sts.with_frac) begin
            state_next = rde_pkg::ST_POINT;
          end else begin
            state_next = rde_pkg::ST_IDLE;
          end
        end
      end
      rde_pkg::ST_POINT: begin
        if (sts.out_free) begin
          cmd.emit_point = 1'b1;
          state_next = rde_pkg::ST_FRAC;
        end
      end
      rde_pkg::ST_FRAC: begin
        if (sts.out_free) begin
          cmd.frac_step = 1'b1;
          if (sts.frac_last) begin
            state_next = rde_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = rde_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/rde_dp.sv
// Datapath of the radix digit emitter: configuration registers, serial divider,
// digit store, fraction multiplier and output register. Depends on rde_pkg.
module rde_dp #(
  parameter int INT_BITS = 32,
  parameter int FRAC_BITS = 32,
  parameter int MAX_FRAC_DIGITS = 31
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [rde_pkg::CFG_W-1:0]     cfg_data,
  input  logic [31:0]                   int_part,
  input  logic [31:0]                   frac_part,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rde_pkg::CHAR_W-1:0]    char_code,
  output logic                          is_last,
  input  rde_pkg::cmd_t                 cmd,
  output rde_pkg::sts_t                 sts
);

  localparam int DEPTH = INT_BITS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int BIT_W = $clog2(INT_BITS);
  localparam int RW = rde_pkg::RADIX_W;
  localparam int LW = rde_pkg::LIMIT_W;

  logic [RW-1:0] radix;
  logic [LW-1:0] frac_digit_limit;

  logic [RW-1:0] base;
  logic [LW-1:0] limit;

  logic [INT_BITS-1:0] quotient_work;
  logic [RW-1:0]       rem;
  logic [BIT_W-1:0]    bit_cnt;
  logic [CNT_W-1:0]    digit_count;
  logic [IDX_W-1:0]    emit_idx;
  logic [RW-1:0]       rd_digit;
  logic [RW-1:0]       digit_store [DEPTH];

  logic [FRAC_BITS-1:0] fraction_work;
  logic [LW-1:0]        used;
  logic                 with_frac;

  logic [RW:0]          rem_shift;
  logic                 quo_bit;
  logic [RW-1:0]        rem_next;
  logic [INT_BITS-1:0]  quotient_next;

  logic [FRAC_BITS+RW-1:0] product;
  logic [FRAC_BITS-1:0]    fraction_next;
  logic [RW-1:0]           frac_digit;
  logic [LW-1:0]           used_next;

  logic                        out_load;
  logic [rde_pkg::CHAR_W-1:0]  char_sel;
  logic                        last_sel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= rde_pkg::RADIX_RESET;
      frac_digit_limit <= rde_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_idx == rde_pkg::CFG_RADIX) begin
        radix <= cfg_data;
      end else begin
        frac_digit_limit <= cfg_data[LW-1:0];
      end
    end
  end

  // Out-of-range bases are clamped, and so is the digit limit.
  always_comb begin
    if (radix < rde_pkg::RADIX_MIN) begin
      base = rde_pkg::RADIX_MIN;
    end else if (radix > rde_pkg::RADIX_MAX) begin
      base = rde_pkg::RADIX_MAX;
    end else begin
      base = radix;
    end
    if (frac_digit_limit > LW'(MAX_FRAC_DIGITS)) begin
      limit = LW'(MAX_FRAC_DIGITS);
    end else begin
      limit = frac_digit_limit;
    end
  end

  // One restoring division step: the quotient bit shifts in at the bottom.
  assign rem_shift = {rem, quotient_work[INT_BITS-1]};
  assign quo_bit = (rem_shift >= {1'b0, base});
  assign rem_next = quo_bit ? RW'(rem_shift - {1'b0, base}) : rem_shift[RW-1:0];
  assign quotient_next = {quotient_work[INT_BITS-2:0], quo_bit};

  assign product = fraction_work * base;
  assign fraction_next = product[FRAC_BITS-1:0];
  assign frac_digit = product[FRAC_BITS+RW-1:FRAC_BITS];
  assign used_next = used + LW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quotient_work <= int_part[INT_BITS-1:0];
      fraction_work <= frac_part[FRAC_BITS-1:0];
      rem <= '0;
      bit_cnt <= '0;
      digit_count <= '0;
      used <= '0;
      with_frac <= (frac_part[FRAC_BITS-1:0] != '0) && (limit != '0);
    end
    if (cmd.div_step) begin
      quotient_work <= quotient_next;
      if (sts.div_last) begin
        digit_store[digit_count[IDX_W-1:0]] <= rem_next;
        digit_count <= digit_count + CNT_W'(1);
        emit_idx <= digit_count[IDX_W-1:0];
        rem <= '0;
        bit_cnt <= '0;
      end else begin
        rem <= rem_next;
        bit_cnt <= bit_cnt + BIT_W'(1);
      end
    end
    if (cmd.rd) begin
      rd_digit <= digit_store[emit_idx];
    end
    if (cmd.emit_digit) begin
      emit_idx <= emit_idx - IDX_W'(1);
    end
    if (cmd.frac_step) begin
      fraction_work <= fraction_next;
      used <= used_next;
    end
  end

  assign sts.div_last = (bit_cnt == BIT_W'(INT_BITS - 1));
  assign sts.div_done = (quotient_next == '0) || (digit_count == CNT_W'(DEPTH - 1));
  assign sts.idx_zero = (emit_idx == '0);
  assign sts.with_frac = with_frac;
  assign sts.out_free = !out_valid || out_ready;
  assign sts.frac_last = (fraction_next == '0) || (used_next >= limit);

  assign out_load = cmd.emit_digit || cmd.emit_point || cmd.frac_step;

  always_comb begin
    char_sel = rde_pkg::ASCII_POINT;
    last_sel = 1'b0;
    if (cmd.emit_digit) begin
      char_sel = rde_pkg::digit_char(rd_digit);
      last_sel = sts.idx_zero && !with_frac;
    end else if (cmd.frac_step) begin
      char_sel = rde_pkg::digit_char(frac_digit);
      last_sel = sts.frac_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      char_code <= char_sel;
      is_last <= last_sel;
    end
  end

endmodule

FILE: src/radix_digit_emitter_top.sv
// Each transaction is accepted in the idle state; each integer digit then takes a full pass of
// the bit-serial divider, and each integer character is sent by a store read and an output load,
// followed by the point and the fraction digits. A stalled output holds the emitting states.
// One transaction is converted at a time; the next is accepted once the last character
// is in the output register. Synchronous active-high reset sets radix 10 and a digit
// limit of 8, and empties the output register; the digit store is not cleared.
module radix_digit_emitter_top #(
  parameter int INT_BITS = 32,
  parameter int FRAC_BITS = 32,
  parameter int MAX_FRAC_DIGITS = 31
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_idx,
  input  logic [rde_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [31:0]                int_part,
  input  logic [31:0]                frac_part,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [rde_pkg::CHAR_W-1:0] char_code,
  output logic                       is_last
);

  rde_pkg::cmd_t cmd;
  rde_pkg::sts_t sts;

  rde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rde_dp #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .int_part  (int_part),
    .frac_part (frac_part),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .is_last   (is_last),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // After an accept the block is in the division state, so no transaction follows directly.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  // Only digit characters and the point ever leave the block.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((char_code >= rde_pkg::ASCII_ZERO && char_code <= rde_pkg::ASCII_NINE) ||
                   (char_code >= rde_pkg::ASCII_A && char_code <= rde_pkg::ASCII_Z) ||
                   (char_code == rde_pkg::ASCII_POINT)))
    else $error("illegal character code");

  // The point is always followed by at least one fraction digit.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_code == rde_pkg::ASCII_POINT) |-> !is_last)
    else $error("point marked as last character");
`endif

endmodule

FILE: test/testbench.sv
// Self-checking testbench for radix_digit_emitter_top: converts numbers to base-N text.
// Depends on rde_pkg and radix_digit_emitter_top; predicts every character internally.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAC_DIGITS = 31;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [31:0] ip;
    logic [31:0] fp;
  } number_t;

  typedef struct packed {
    logic [rde_pkg::CHAR_W-1:0] code;
    logic                       last;
  } char_rec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_idx = rde_pkg::CFG_RADIX;
  logic [rde_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] int_part = '0;
  logic [31:0] frac_part = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [rde_pkg::CHAR_W-1:0] char_code;
  logic is_last;

  // Register values as the block holds them, mirrored on every write.
  logic [rde_pkg::RADIX_W-1:0] cur_radix = rde_pkg::RADIX_RESET;
  logic [rde_pkg::LIMIT_W-1:0] cur_limit = rde_pkg::LIMIT_RESET;

  number_t   pending_numbers[$];
  char_rec_t expected_chars[$];

  int unsigned cycle_count = 0;
  int numbers_sent = 0;
  int chars_checked = 0;
  int error_count = 0;
  int settings_used = 0;

  radix_digit_emitter_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .int_part(int_part),
    .frac_part(frac_part),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .char_code(char_code),
    .is_last(is_last)
  );

  always #1 clk = ~clk;

  function automatic logic [rde_pkg::CHAR_W-1:0] ascii_of(
    input logic [rde_pkg::RADIX_W-1:0] d);
    if (d < 10) begin
      return rde_pkg::ASCII_ZERO + rde_pkg::CHAR_W'(d);
    end
    return rde_pkg::ASCII_A + rde_pkg::CHAR_W'(d) - rde_pkg::CHAR_W'(10);
  endfunction

  task automatic expect_char(input logic [rde_pkg::CHAR_W-1:0] code, input logic last);
    char_rec_t rec;
    rec.code = code;
    rec.last = last;
    expected_chars = {expected_chars, rec};
  endtask

  // Works out the text of one number under the current settings and queues it.
  task automatic predict_text(input logic [31:0] ip, input logic [31:0] fp);
    logic [rde_pkg::RADIX_W-1:0] base;
    logic [rde_pkg::LIMIT_W-1:0] lim;
    logic [rde_pkg::RADIX_W-1:0] digits[32];
    logic [31:0] q;
    logic [31:0] f;
    logic [63:0] prod;
    logic frac_on;
    logic done;
    int n;
    int used;
    base = cur_radix;
    if (base < rde_pkg::RADIX_MIN) begin
      base = rde_pkg::RADIX_MIN;
    end
    if (base > rde_pkg::RADIX_MAX) begin
      base = rde_pkg::RADIX_MAX;
    end
    lim = (cur_limit > MAX_FRAC_DIGITS) ? rde_pkg::LIMIT_W'(MAX_FRAC_DIGITS) : cur_limit;
    q = ip;
    n = 0;
    if (q == 0) begin
      digits[0] = '0;
      n = 1;
    end else begin
      while (q != 0) begin
        digits[n] = rde_pkg::RADIX_W'(q % base);
        q = q / base;
        n++;
      end
    end
    frac_on = (fp != 0) && (lim != 0);
    for (int i = n - 1; i >= 0; i--) begin
      expect_char(ascii_of(digits[i]), (i == 0) && !frac_on);
    end
    if (frac_on) begin
      expect_char(rde_pkg::ASCII_POINT, 1'b0);
      f = fp;
      used = 0;
      done = 1'b0;
      while (!done) begin
        prod = 64'(f) * 64'(base);
        f = prod[31:0];
        used++;
        done = (f == 0) || (used >= lim);
        expect_char(ascii_of(prod[32 +: rde_pkg::RADIX_W]), done);
      end
    end
  endtask

  // Sender: bursts of transactions separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  number_t next_num;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_text(int_part, frac_part);
        numbers_sent++;
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_numbers.size() > 0) begin
        next_num = pending_numbers.pop_front();
        in_valid <= 1'b1;
        int_part <= next_num.ip;
        frac_part <= next_num.fp;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each character and stalls in modes that change over time.
  int rx_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  char_rec_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual code %h last %b",
                   $time, char_code, is_last);
          error_count++;
        end else begin
          want = expected_chars.pop_front();
          if (char_code !== want.code) begin
            $display("%0t: char_code mismatch: expected %h, actual %h",
                     $time, want.code, char_code);
            error_count++;
          end
          if (is_last !== want.last) begin
            $display("%0t: is_last mismatch: expected %b, actual %b",
                     $time, want.last, is_last);
            error_count++;
          end
        end
        // One long hold-off mid-number while more numbers wait, so the input backs up.
        if (!hold_done && chars_checked >= 200 && !is_last && pending_numbers.size() > 2) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rx_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(30, 200);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          0: begin
            out_ready <= 1'b1;
          end
          1: begin
            out_ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            out_ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [rde_pkg::CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
  endtask

  task automatic set_config(input logic [rde_pkg::RADIX_W-1:0] radix,
                            input logic [rde_pkg::LIMIT_W-1:0] limit);
    write_reg(rde_pkg::CFG_RADIX, rde_pkg::CFG_W'(radix));
    write_reg(rde_pkg::CFG_FRAC_LIMIT, rde_pkg::CFG_W'(limit));
    cur_radix = radix;
    cur_limit = limit;
    settings_used++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_number(input logic [31:0] ip, input logic [31:0] fp);
    number_t num;
    num.ip = ip;
    num.fp = fp;
    pending_numbers = {pending_numbers, num};
  endtask

  // Block is idle once nothing is queued, offered or still owed.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_numbers.size() != 0 || in_valid || expected_chars.size() != 0);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'($urandom_range(0, 255));
      3: return $urandom >> $urandom_range(0, 31);
      4: return $urandom << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [rde_pkg::RADIX_W-1:0] r;
    logic [rde_pkg::LIMIT_W-1:0] l;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero, full width, a terminating fraction, a cut-off fraction.
    add_number(32'd0, 32'd0);
    add_number(32'hFFFF_FFFF, 32'd0);
    add_number(32'd123, 32'h8000_0000);
    add_number(32'd0, 32'hFFFF_FFFF);
    add_number(32'd1, 32'd1);
    wait_drained();

    // Binary with the longest fraction gives the most characters per number.
    set_config(6'd2, 5'd31);
    add_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_number(32'h8000_0000, 32'h0000_0001);
    wait_drained();

    // A zero digit limit drops the point even when the fraction is nonzero.
    set_config(6'd36, 5'd0);
    add_number(32'hFFFF_FFFF, 32'h1234_5678);
    add_number(32'd35, 32'd0);
    wait_drained();

    // Out-of-range radix values clamp to the nearest legal base.
    set_config(6'd0, 5'd31);
    add_number(32'hA5A5_A5A5, 32'hC000_0000);
    wait_drained();
    set_config(6'd1, 5'd5);
    add_number(32'd7, 32'h4000_0000);
    wait_drained();
    set_config(6'd63, 5'd31);
    add_number(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();
    set_config(6'd37, 5'd3);
    add_number(32'd1295, 32'h8000_0000);
    wait_drained();
    set_config(6'd16, 5'd1);
    add_number(32'hDEAD_BEEF, 32'h0000_0001);
    add_number(32'h0000_0010, 32'h0800_0000);
    wait_drained();

    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 0) begin
        r = 6'd2;
        l = 5'd31;
      end else if (phase == 1) begin
        r = 6'd36;
        l = 5'd31;
      end else begin
        r = ($urandom_range(0, 7) == 0) ? rde_pkg::RADIX_W'($urandom_range(0, 63))
                                       : rde_pkg::RADIX_W'($urandom_range(2, 36));
        l = rde_pkg::LIMIT_W'($urandom_range(0, 31));
      end
      set_config(r, l);
      for (int i = 0; i < 16; i++) begin
        add_number(rand_word(), rand_word());
      end
      wait_drained();
    end

    repeat (50) @(posedge clk);
    $display("Converted %0d numbers under %0d register settings, %0d characters checked.",
             numbers_sent, settings_used, chars_checked);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
